/* sv/sha1_byte_stream_hasher_macros.svh */
// Assertion macros used by the checker file.
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 hasher assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 hasher assertion failed");

`endif

/* sv/sha1h_pkg.sv */
// Shared types, constants and round helpers for the SHA-1 byte stream hasher.
`default_nettype none

package sha1h_pkg;

    typedef enum logic [1:0] {
        GRP_CH   = 2'd0,
        GRP_PAR1 = 2'd1,
        GRP_MAJ  = 2'd2,
        GRP_PAR2 = 2'd3
    } grp_t;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0,
        32'h10325476,
        32'h98BADCFE,
        32'hEFCDAB89,
        32'h67452301
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [5:0] POS_LENGTH = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] ROUND_CH   = 7'd20;
    localparam logic [6:0] ROUND_PAR1 = 7'd40;
    localparam logic [6:0] ROUND_MAJ  = 7'd60;

    typedef struct packed {
        logic       byte_shift;
        logic [7:0] byte_val;
        logic       round_shift;
        logic       expand;
    } sched_ctrl_t;

    typedef struct packed {
        logic load_work;
        logic do_round;
        logic fold;
        logic init_hash;
        grp_t grp;
    } core_ctrl_t;

    function automatic logic [31:0] round_k(input grp_t g);
        logic [31:0] k;
        unique case (g)
            GRP_CH:   k = 32'h5A827999;
            GRP_PAR1: k = 32'h6ED9EBA1;
            GRP_MAJ:  k = 32'h8F1BBCDC;
            GRP_PAR2: k = 32'hCA62C1D6;
            default:  k = 32'h5A827999;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] round_f(input grp_t g, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (g)
            GRP_CH:   f = (b & c) | (~b & d);
            GRP_MAJ:  f = (b & c) | (b & d) | (c & d);
            GRP_PAR1: f = b ^ c ^ d;
            GRP_PAR2: f = b ^ c ^ d;
            default:  f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* sv/sha1h_msg_sched.sv */
// Message window: gathers bytes big-endian and expands the schedule one word per round.
`default_nettype none

module sha1h_msg_sched (
    input  wire logic                  clk,
    input  wire sha1h_pkg::sched_ctrl_t ctrl,
    output logic [31:0]                w
);

    logic [31:0] win_reg  [16];
    logic [31:0] win_next [16];
    logic [31:0] mixed;

    assign mixed = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w     = ctrl.expand ? {mixed[30:0], mixed[31]} : win_reg[0];

    always_comb
    begin
        win_next = win_reg;
        priority if (ctrl.byte_shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], ctrl.byte_val};
        end
        else if (ctrl.round_shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = w;
        end
        else
        begin
            win_next = win_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

/* sv/sha1h_round_core.sv */
// Round unit: working variables, one SHA-1 round per cycle while do_round is set, and the hash words.
`default_nettype none

module sha1h_round_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha1h_pkg::core_ctrl_t ctrl,
    input  wire logic [31:0]           w,
    output logic [4:0][31:0]           h
);

    logic [31:0]      a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]      a_next, b_next, c_next, d_next, e_next;
    logic [4:0][31:0] h_reg, h_next;
    logic [31:0]      temp;

    assign temp = {a_reg[26:0], a_reg[31:27]}
                + sha1h_pkg::round_f(ctrl.grp, b_reg, c_reg, d_reg)
                + e_reg + sha1h_pkg::round_k(ctrl.grp) + w;

    assign h = h_reg;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        priority if (ctrl.load_work)
        begin
            a_next = h_reg[0];
            b_next = h_reg[1];
            c_next = h_reg[2];
            d_next = h_reg[3];
            e_next = h_reg[4];
        end
        else if (ctrl.do_round)
        begin
            a_next = temp;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
        else
        begin
            a_next = a_reg;
            b_next = b_reg;
            c_next = c_reg;
            d_next = d_reg;
            e_next = e_reg;
        end
    end

    always_comb
    begin
        h_next = h_reg;
        priority if (ctrl.init_hash)
        begin
            h_next = sha1h_pkg::H_INIT;
        end
        else if (ctrl.fold)
        begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end
        else
        begin
            h_next = h_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= sha1h_pkg::H_INIT;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

endmodule

`default_nettype wire

/* sv/sha1_byte_stream_hasher.sv */
// SHA-1 byte stream hasher top level: sequencer, byte count, padding and digest register.
// One message byte per item, gathered big-endian into 64-byte blocks. An item that does
// not fill a block and has last clear leaves the input ready for the next item. The item
// that fills a block holds the input while the shared round unit runs the 80 rounds and
// then folds the working variables into the hash words.
// An item with last set runs the padding one byte per cycle between compressions, through
// the same window (0x80, zeros, then the 64-bit bit length), one or two more block
// compressions, and the S_OUT state, which moves the digest to the output register once
// no digest is held stalled at the output.
// The digest register frees the input side, so the next message may start while the
// digest waits to be taken. After the digest the hash words return to their initial
// values and the byte count to zero.
`default_nettype none

module sha1_byte_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        last,
    output logic             digest_valid,
    input  wire logic        digest_stall,
    output logic [31:0]      digest_word0,
    output logic [31:0]      digest_word1,
    output logic [31:0]      digest_word2,
    output logic [31:0]      digest_word3,
    output logic [31:0]      digest_word4
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ROUND  = 7'b0000010,
        S_FOLD   = 7'b0000100,
        S_PAD80  = 7'b0001000,
        S_PADZ   = 7'b0010000,
        S_PADLEN = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    state_t                 ret_reg, ret_next;
    logic [6:0]             round_reg, round_next;
    logic [5:0]             pos_reg, pos_next;
    logic [63:0]            count_reg, count_next;
    logic [63:0]            len_reg, len_next;
    logic                   out_valid_reg, out_valid_next;
    logic [4:0][31:0]       digest_reg, digest_next;
    sha1h_pkg::sched_ctrl_t sc;
    sha1h_pkg::core_ctrl_t  cc;
    sha1h_pkg::grp_t        grp;
    logic [31:0]            w;
    logic [4:0][31:0]       h;

    sha1h_msg_sched u_sched (
        .clk  (clk),
        .ctrl (sc),
        .w    (w)
    );

    sha1h_round_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cc),
        .w     (w),
        .h     (h)
    );

    always_comb
    begin
        priority if (round_reg < sha1h_pkg::ROUND_CH)
        begin
            grp = sha1h_pkg::GRP_CH;
        end
        else if (round_reg < sha1h_pkg::ROUND_PAR1)
        begin
            grp = sha1h_pkg::GRP_PAR1;
        end
        else if (round_reg < sha1h_pkg::ROUND_MAJ)
        begin
            grp = sha1h_pkg::GRP_MAJ;
        end
        else
        begin
            grp = sha1h_pkg::GRP_PAR2;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        round_next     = round_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        digest_next    = digest_reg;
        sc             = '0;
        cc             = '0;
        cc.grp         = grp;

        if (out_valid_reg && !digest_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (byte_valid)
                begin
                    if (byte_present)
                    begin
                        sc.byte_shift = 1'b1;
                        sc.byte_val   = data_byte;
                        count_next    = count_reg + 64'd1;
                        pos_next      = pos_reg + 6'd1;
                        if (pos_reg == sha1h_pkg::POS_LAST)
                        begin
                            cc.load_work = 1'b1;
                            round_next   = '0;
                            state_next   = S_ROUND;
                            ret_next     = last ? S_PAD80 : S_IDLE;
                        end
                        else if (last)
                        begin
                            state_next = S_PAD80;
                        end
                    end
                    else if (last)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                sc.byte_shift = 1'b1;
                sc.byte_val   = sha1h_pkg::PAD_MARK;
                pos_next      = pos_reg + 6'd1;
                len_next      = {count_reg[60:0], 3'b000};
                state_next    = S_PADZ;
                if (pos_reg == sha1h_pkg::POS_LAST)
                begin
                    cc.load_work = 1'b1;
                    round_next   = '0;
                    state_next   = S_ROUND;
                    ret_next     = S_PADZ;
                end
            end
            S_PADZ:
            begin
                if (pos_reg == sha1h_pkg::POS_LENGTH)
                begin
                    state_next = S_PADLEN;
                end
                else
                begin
                    sc.byte_shift = 1'b1;
                    sc.byte_val   = sha1h_pkg::PAD_ZERO;
                    pos_next      = pos_reg + 6'd1;
                    if (pos_reg == sha1h_pkg::POS_LAST)
                    begin
                        cc.load_work = 1'b1;
                        round_next   = '0;
                        state_next   = S_ROUND;
                        ret_next     = S_PADZ;
                    end
                end
            end
            S_PADLEN:
            begin
                sc.byte_shift = 1'b1;
                sc.byte_val   = len_reg[63:56];
                len_next      = {len_reg[55:0], 8'h00};
                pos_next      = pos_reg + 6'd1;
                if (pos_reg == sha1h_pkg::POS_LAST)
                begin
                    cc.load_work = 1'b1;
                    round_next   = '0;
                    state_next   = S_ROUND;
                    ret_next     = S_OUT;
                end
            end
            S_ROUND:
            begin
                cc.do_round    = 1'b1;
                sc.round_shift = 1'b1;
                sc.expand      = (round_reg[6:4] != 3'd0);
                round_next     = round_reg + 7'd1;
                if (round_reg == sha1h_pkg::ROUND_LAST)
                begin
                    round_next = '0;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cc.fold    = 1'b1;
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    digest_next    = h;
                    out_valid_next = 1'b1;
                    cc.init_hash   = 1'b1;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            round_reg     <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            round_reg     <= round_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        digest_reg <= digest_next;
    end

    assign byte_stall   = (state_reg != S_IDLE);
    assign digest_valid = out_valid_reg;
    assign digest_word0 = digest_reg[0];
    assign digest_word1 = digest_reg[1];
    assign digest_word2 = digest_reg[2];
    assign digest_word3 = digest_reg[3];
    assign digest_word4 = digest_reg[4];

endmodule

`default_nettype wire

/* sv/sha1h_checker.sv */
// Port-level checker for the SHA-1 byte stream hasher and its bind.
`default_nettype none

`include "sha1_byte_stream_hasher_macros.svh"

module sha1h_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_valid,
    input wire logic        byte_stall,
    input wire logic [7:0]  data_byte,
    input wire logic        byte_present,
    input wire logic        last,
    input wire logic        digest_valid,
    input wire logic        digest_stall,
    input wire logic [31:0] digest_word0,
    input wire logic [31:0] digest_word1,
    input wire logic [31:0] digest_word2,
    input wire logic [31:0] digest_word3,
    input wire logic [31:0] digest_word4
);

    logic item_in;

    assign item_in = byte_valid && !byte_stall;

    `SBH_ASSERT_NXT(a_last_blocks_input, item_in && last, byte_stall)
    `SBH_ASSERT_NXT(a_empty_item_keeps_ready, item_in && !byte_present && !last, !byte_stall)
    `SBH_ASSERT_IMP(a_digest_after_busy, $rose(digest_valid), $past(byte_stall))
    `SBH_ASSERT_NXT(a_digest_held, digest_valid && digest_stall, digest_valid && $stable(digest_word0) && $stable(digest_word4))

endmodule

bind sha1_byte_stream_hasher sha1h_checker u_sha1h_checker (.*);

`default_nettype wire

/* tb/sv/sha1_byte_stream_hasher_tb.sv */
// Self-checking testbench for the SHA-1 byte stream hasher: directed and random messages.
module sha1_byte_stream_hasher_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 250;
    localparam int RANDOM_ITEMS   = 400;
    localparam int RANDOM_DIGESTS = 10;
    localparam int TAIL_ITEMS     = 70;
    localparam int TAIL_DIGESTS   = 4;
    localparam int ROUNDS         = 80;

    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    typedef logic [4:0][31:0] digest_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte    = 8'h00;
    logic        byte_present = 1'b0;
    logic        last         = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;

    digest_t     hash_state;
    logic [7:0]  msg_block [64];
    logic [63:0] msg_len;
    digest_t     expected_digests [$];
    int          fail_count        = 0;
    int          digests_predicted = 0;
    int          quiet_cycles      = 0;
    bit          idle_enable       = 1'b1;

    sha1_byte_stream_hasher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last         (last),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word0 (digest_word0),
        .digest_word1 (digest_word1),
        .digest_word2 (digest_word2),
        .digest_word3 (digest_word3),
        .digest_word4 (digest_word4)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        hash_state = sha1h_pkg::H_INIT;
        msg_len    = '0;
    endfunction

    function automatic void mix_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < ROUNDS; r++)
        begin
            if (r >= 16)
                w[r % 16] = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16]
                                 ^ w[r % 16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            t = rotl(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
        hash_state[4] = hash_state[4] + e;
    endfunction

    function automatic void predict_digest(input logic [7:0] b, input logic present,
                                           input logic fin);
        logic [63:0] bit_len;
        int          pos;
        if (present)
        begin
            pos = msg_len[5:0];
            msg_block[pos] = b;
            msg_len = msg_len + 64'd1;
            if (pos == 63)
                mix_block();
        end
        if (!fin)
            return;
        pos = msg_len[5:0];
        msg_block[pos] = 8'h80;
        for (int i = pos + 1; i < 64; i++)
            msg_block[i] = 8'h00;
        if (pos >= 56)
        begin
            mix_block();
            for (int i = 0; i < 64; i++)
                msg_block[i] = 8'h00;
        end
        bit_len = msg_len << 3;
        for (int i = 0; i < 8; i++)
            msg_block[56 + i] = bit_len[63 - 8 * i -: 8];
        mix_block();
        expected_digests.push_back(hash_state);
        digests_predicted++;
        restart_hash();
    endfunction

    task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        byte_valid   <= 1'b1;
        data_byte    <= b;
        byte_present <= present;
        last         <= fin;
        do
            @(posedge clk);
        while (byte_stall);
        predict_digest(b, present, fin);
    endtask

    task automatic run_random_messages(input int min_items, input int min_digests,
                                       input bit vary_idle);
        int items;
        int digests_start;
        int kind;
        int msg_bytes;
        bit separate_end;
        items = 0;
        digests_start = digests_predicted;
        while (items < min_items || digests_predicted - digests_start < min_digests)
        begin
            if (vary_idle)
                idle_enable = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 19);
            if (kind < 15)
                msg_bytes = $urandom_range(0, 8);
            else if (kind < 19)
                msg_bytes = $urandom_range(52, 68);
            else
                msg_bytes = $urandom_range(100, 140);
            separate_end = (msg_bytes == 0) || ($urandom_range(0, 1) == 0);
            for (int i = 0; i < msg_bytes; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item($urandom_range(0, 255), 1'b0, 1'b0);
                send_item($urandom_range(0, 255), 1'b1, !separate_end && i == msg_bytes - 1);
                items++;
            end
            if (separate_end)
            begin
                send_item($urandom_range(0, 255), 1'b0, 1'b1);
                items++;
            end
        end
    endtask

    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_ignored_items();
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        idle_enable = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_messages(RANDOM_ITEMS, RANDOM_DIGESTS, 1'b1);
    endtask

    task automatic test_streaming_tail();
        idle_enable = 1'b0;
        run_random_messages(TAIL_ITEMS, TAIL_DIGESTS, 1'b0);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                digest_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                digest_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        digest_t got;
        digest_t want;
        if (rst_n && digest_valid && !digest_stall)
        begin
            got = {digest_word4, digest_word3, digest_word2, digest_word1, digest_word0};
            if (expected_digests.size() == 0)
            begin
                $display("%0t: unexpected digest, expected none, actual %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = expected_digests.pop_front();
                for (int i = 0; i < 5; i++)
                    if (got[i] !== want[i])
                    begin
                        $display("%0t: digest_word%0d expected %h actual %h",
                                 $time, i, want[i], got[i]);
                        fail_count++;
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (digest_valid && !digest_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        restart_hash();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_message();
        test_ignored_items();
        test_byte_extremes();
        test_back_to_back();
        test_random_traffic();
        test_streaming_tail();
        byte_valid <= 1'b0;
        while (expected_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
